// ===== rtl/tsbd_pkg.sv =====
`timescale 1ns / 1ps
package tsbd_pkg;

  // Compressed blocks with fewer points than this are stored raw.
  localparam logic [15:0] RAW_LIMIT = 16'd5;
  // Value byte code that means a full raw value.
  localparam logic [7:0] CODE_FULL = 8'hff;
  // Depth of the result queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_DATA_KIND   = 3'd0;
  localparam logic [2:0] REG_CODEC_INFO  = 3'd1;
  localparam logic [2:0] REG_POINT_COUNT = 3'd2;
  localparam logic [2:0] REG_START_TIME  = 3'd3;
  localparam logic [2:0] REG_END_TIME    = 3'd4;
  localparam logic [2:0] REG_USE_START   = 3'd5;
  localparam logic [2:0] REG_USE_END     = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RAW    = 3'd1,
    PH_BASE   = 3'd2,
    PH_HIGH   = 3'd3,
    PH_DTIME  = 3'd4,
    PH_DVALUE = 3'd5,
    PH_RUN    = 3'd6
  } phase_t;

  typedef enum logic {
    KIND_POINT  = 1'b0,
    KIND_MARKER = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] point_time;
    logic [63:0] point_value;
    logic [15:0] kept_total;
  } result_t;

  // Results of one byte, handed from the front to the queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

// ===== rtl/tsbd_front.sv =====
`timescale 1ns / 1ps
module tsbd_front import tsbd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         block_start,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output result_pair_t results
);

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  byte_index;
    logic [15:0] points_left;
    logic [15:0] kept_count;
    logic [63:0] time_accum;
    logic [63:0] value_accum;
    logic [63:0] high_time_bits;
    logic [63:0] gather_word;
    logic [63:0] base_bits;
    logic        stopped;
  } dec_state_t;

  typedef struct packed {
    dec_state_t   s;
    result_pair_t r;
  } step_t;

  typedef struct packed {
    logic        data_kind;
    logic [15:0] codec_info;
    logic [15:0] point_count;
    logic [63:0] start_time;
    logic [63:0] end_time;
    logic        use_start;
    logic        use_end;
  } cfg_t;

  cfg_t       cfg;
  dec_state_t state;
  step_t      step;

  function automatic logic [3:0] value_bytes(input cfg_t c);
    logic [7:0] v;
    logic [3:0] n;
    v = c.codec_info[15:8];
    n = '0;
    if (c.data_kind) begin
      for (int i = 0; i < 8; i++) n = n + {3'b0, v[i]};
    end else if (v == CODE_FULL) begin
      n = 4'd8;
    end else begin
      for (int i = 0; i < 8; i++) if (v[i] && n == 4'd0) n = 4'(8 - i);
    end
    return n;
  endfunction

  function automatic logic [3:0] next_lane(input cfg_t c, input logic [3:0] from);
    logic [3:0] r;
    logic       found;
    r = 4'd8;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && 4'(i) >= from && c.codec_info[8 + i]) begin
        r = 4'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic step_t push(input step_t x, input logic k, input logic [63:0] t,
                                 input logic [63:0] v, input logic [15:0] tot);
    result_t e;
    step_t   y;
    y = x;
    e.kind = k;
    e.point_time = t;
    e.point_value = v;
    e.kept_total = tot;
    if (y.r.count == 2'd0) y.r.r0 = e;
    else y.r.r1 = e;
    y.r.count = y.r.count + 2'd1;
    return y;
  endfunction

  function automatic step_t finish_point(input step_t x, input cfg_t c, input logic [63:0] t,
                                         input logic [63:0] v, input logic raw);
    step_t y;
    logic  keep;
    y = x;
    keep = 1'b0;
    if (raw) begin
      keep = (!c.use_start || t >= c.start_time) && (!c.use_end || t < c.end_time);
    end else if (!y.s.stopped) begin
      if (c.use_end && t >= c.end_time) y.s.stopped = 1'b1;
      else if (!c.use_start || t >= c.start_time) keep = 1'b1;
    end
    if (keep) begin
      y = push(y, KIND_POINT, t, v, 16'd0);
      y.s.kept_count = y.s.kept_count + 16'd1;
    end
    if (y.s.points_left != 16'd0) y.s.points_left = y.s.points_left - 16'd1;
    if (y.s.points_left == 16'd0) begin
      y = push(y, KIND_MARKER, 64'd0, 64'd0, y.s.kept_count);
      y.s.phase = PH_IDLE;
    end
    return y;
  endfunction

  function automatic step_t begin_value(input step_t x, input cfg_t c);
    step_t y;
    y = x;
    y.s.gather_word = '0;
    y.s.phase = PH_DVALUE;
    if (c.data_kind) y.s.byte_index = next_lane(c, 4'd0);
    else if (c.codec_info[15:8] == CODE_FULL) y.s.byte_index = 4'd0;
    else y.s.byte_index = value_bytes(c) - 4'd1;
    return y;
  endfunction

  function automatic step_t begin_point(input step_t x, input cfg_t c);
    step_t y;
    y = x;
    y.s.gather_word = '0;
    if (c.codec_info[3:0] != 4'd0) begin
      y.s.phase = PH_DTIME;
      y.s.byte_index = c.codec_info[3:0] - 4'd1;
    end else if (value_bytes(c) == 4'd0) begin
      y.s.phase = PH_RUN;
    end else begin
      y.s.time_accum = y.s.time_accum + y.s.high_time_bits;
      y = begin_value(y, c);
    end
    return y;
  endfunction

  function automatic step_t complete(input step_t x, input cfg_t c);
    step_t       y;
    logic [63:0] g;
    logic [63:0] v;
    logic [63:0] lanes;
    y = x;
    g = y.s.gather_word;
    for (int i = 0; i < 8; i++) lanes[8*i +: 8] = {8{c.codec_info[8 + i]}};
    if (c.data_kind) begin
      v = (y.s.base_bits & ~lanes) | g;
    end else if (c.codec_info[15:8] == CODE_FULL) begin
      v = g;
    end else begin
      // Magnitude with the sign in bit zero.
      y.s.value_accum = g[0] ? y.s.value_accum - {1'b0, g[63:1]}
                             : y.s.value_accum + {1'b0, g[63:1]};
      v = y.s.value_accum;
    end
    y.s.gather_word = '0;
    y = finish_point(y, c, y.s.time_accum, v, 1'b0);
    if (y.s.phase != PH_IDLE) y = begin_point(y, c);
    return y;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_kind <= 1'b0;
      cfg.codec_info <= 16'hffff;
      cfg.point_count <= '0;
      cfg.start_time <= '0;
      cfg.end_time <= '1;
      cfg.use_start <= 1'b0;
      cfg.use_end <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DATA_KIND:   cfg.data_kind <= cfg_data[0];
        REG_CODEC_INFO:  cfg.codec_info <= cfg_data[15:0];
        REG_POINT_COUNT: cfg.point_count <= cfg_data[15:0];
        REG_START_TIME:  cfg.start_time <= cfg_data;
        REG_END_TIME:    cfg.end_time <= cfg_data;
        REG_USE_START:   cfg.use_start <= cfg_data[0];
        REG_USE_END:     cfg.use_end <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decode one byte: next state and up to two results.
  always_comb begin
    logic [3:0]  p;
    logic [63:0] b64;
    logic [63:0] v;
    logic        done;
    step = '0;
    step.s = state;
    done = 1'b0;
    b64 = {56'd0, data_byte};
    p = state.byte_index;
    v = '0;
    if (block_start) begin
      step.s = '0;
      step.s.points_left = cfg.point_count;
      if (cfg.point_count == 16'd0) begin
        step.s.phase = PH_IDLE;
        step = push(step, KIND_MARKER, 64'd0, 64'd0, 16'd0);
        done = 1'b1;
      end else begin
        step.s.phase = (cfg.point_count < RAW_LIMIT) ? PH_RAW : PH_BASE;
      end
    end
    p = step.s.byte_index;
    if (!done) begin
      unique case (step.s.phase)
        PH_RAW, PH_BASE: begin
          step.s.gather_word = step.s.gather_word | (b64 << {p[2:0], 3'b000});
          if (p == 4'd7) begin
            step.s.time_accum = step.s.gather_word;
            step.s.gather_word = '0;
            step.s.byte_index = 4'd8;
          end else if (p < 4'd15) begin
            step.s.byte_index = p + 4'd1;
          end else begin
            v = step.s.gather_word;
            step.s.gather_word = '0;
            step.s.byte_index = 4'd0;
            if (step.s.phase == PH_RAW) begin
              step = finish_point(step, cfg, step.s.time_accum, v, 1'b1);
            end else begin
              step.s.base_bits = v;
              step.s.value_accum = v;
              step = finish_point(step, cfg, step.s.time_accum, v, 1'b0);
              if (step.s.phase != PH_IDLE) begin
                if (cfg.codec_info[7:4] > cfg.codec_info[3:0]) begin
                  step.s.phase = PH_HIGH;
                  step.s.byte_index = cfg.codec_info[7:4] - 4'd1;
                end else begin
                  step = begin_point(step, cfg);
                end
              end
            end
          end
        end
        PH_HIGH: begin
          if (p < 4'd8)
            step.s.high_time_bits = step.s.high_time_bits | (b64 << {p[2:0], 3'b000});
          if (p <= cfg.codec_info[3:0]) step = begin_point(step, cfg);
          else step.s.byte_index = p - 4'd1;
        end
        PH_DTIME: begin
          step.s.gather_word = {step.s.gather_word[55:0], data_byte};
          if (p == 4'd0) begin
            step.s.time_accum = step.s.time_accum
                              + (step.s.gather_word | step.s.high_time_bits);
            step.s.gather_word = '0;
            if (value_bytes(cfg) == 4'd0) step = complete(step, cfg);
            else step = begin_value(step, cfg);
          end else begin
            step.s.byte_index = p - 4'd1;
          end
        end
        PH_DVALUE: begin
          if (cfg.data_kind) begin
            step.s.gather_word = step.s.gather_word | (b64 << {p[2:0], 3'b000});
            p = next_lane(cfg, {1'b0, p[2:0]} + 4'd1);
            if (p >= 4'd8) step = complete(step, cfg);
            else step.s.byte_index = p;
          end else if (cfg.codec_info[15:8] == CODE_FULL) begin
            step.s.gather_word = step.s.gather_word | (b64 << {p[2:0], 3'b000});
            if (p[2:0] == 3'd7) step = complete(step, cfg);
            else step.s.byte_index = {1'b0, p[2:0]} + 4'd1;
          end else begin
            step.s.gather_word = {step.s.gather_word[55:0], data_byte};
            if (p == 4'd0) step = complete(step, cfg);
            else step.s.byte_index = p - 4'd1;
          end
        end
        PH_RUN: begin
          step.s.time_accum = step.s.time_accum + step.s.high_time_bits;
          step.s.gather_word = '0;
          step = complete(step, cfg);
        end
        default: ;
      endcase
    end
  end

  // Decoder state advances on each accepted byte; the idle phase encodes as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= step.s;
    end
  end

  always_comb begin
    results = step.r;
    if (!accept) results.count = 2'd0;
  end

endmodule

// ===== rtl/tsbd_queue.sv =====
`timescale 1ns / 1ps
module tsbd_queue import tsbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  result_pair_t push,
  output logic         room_for_two,
  output logic         out_valid,
  input  logic         out_stall,
  output result_t      head
);

  localparam int AW = $clog2(DEPTH);

  result_t       entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic          pop;

  assign pop = out_valid && !out_stall;
  assign out_valid = fill != '0;
  assign head = entries[rd_ptr];
  assign room_for_two = fill <= (AW + 1)'(DEPTH - 2);

  // Up to two results are written per cycle; one leaves per transfer.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.r0;
    if (push.count == 2'd2) entries[AW'(wr_ptr + 1'b1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (AW + 1)'(push.count) - (AW + 1)'(pop);
    end
  end

endmodule

// ===== rtl/time_series_block_decoder_top.sv =====
`timescale 1ns / 1ps
// Time-series block decoder. Bytes of a block enter one per transfer on the input
// channel, the first flagged by block_start; decoded points within the time window
// leave on the output channel, followed by an end of block marker with the kept
// count. One byte is accepted per clock cycle while in_stall is low. Each byte can
// yield up to two results, held in a small queue; input stalls when it has room for
// fewer than two, so with an output that never stalls the rate stays one byte per
// cycle. Users write registers on the plain write port only while idle; not enforced.
module time_series_block_decoder_top import tsbd_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        block_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [63:0] point_time,
  output logic [63:0] point_value,
  output logic [15:0] kept_total,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  result_pair_t pair;
  result_t      head;
  logic         room;
  logic         accept;

  assign in_stall = !room;
  assign accept = in_valid && room;

  // Front: accepts bytes and decodes the block.
  tsbd_front u_front (
    .clk, .rst, .accept, .data_byte, .block_start,
    .cfg_write, .cfg_index, .cfg_data, .results(pair)
  );

  // Back: queues results and hands them out one per transfer.
  tsbd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst, .push(pair), .room_for_two(room),
    .out_valid, .out_stall, .head
  );

  assign kind = head.kind;
  assign point_time = head.point_time;
  assign point_value = head.point_value;
  assign kept_total = head.kept_total;

endmodule
